// File: rtl/aph2d_pkg.sv
// Shared types, constants and state codes of the angle pair histogram.
package aph2d_pkg;

   localparam int BINS_DEFAULT = 64;

   localparam int ANGLE_W = 15;
   localparam int QUERY_W = 6;
   localparam int BIN_OUT_W = 6;
   localparam int COUNT_W = 20;
   localparam int NORM_W = 17;
   localparam int WIDTH_W = 15;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 15'd640;

   // divider: 20-bit divisor and remainder, 17 quotient bits
   localparam int DIV_R_W = 20;
   localparam int DIV_Q_W = 17;
   localparam int DIV_STEP_W = 5;
   localparam logic [DIV_STEP_W-1:0] ANGLE_STEPS = 5'd15;
   localparam logic [DIV_STEP_W-1:0] NORM_STEPS = 5'd17;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic REG_BIN_WIDTH_X = 1'b0;
   localparam logic REG_BIN_WIDTH_Y = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [ANGLE_W-1:0]   angle_x;
      logic [ANGLE_W-1:0]   angle_y;
      logic [QUERY_W-1:0]   query_x;
      logic [QUERY_W-1:0]   query_y;
   } req_type;

   typedef struct packed {
      logic [BIN_OUT_W-1:0] bin_x;
      logic [BIN_OUT_W-1:0] bin_y;
      logic [COUNT_W-1:0]   bin_count;
      logic [NORM_W-1:0]    norm_value;
      logic [COUNT_W-1:0]   peak;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_R_W-1:0]    rem_init;
      logic [DIV_Q_W-1:0]    num_init;
      logic [DIV_R_W-1:0]    divisor;
      logic [DIV_STEP_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIV_Q_W-1:0]    quotient;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_X_START,
      ST_X_WAIT,
      ST_Y_START,
      ST_Y_WAIT,
      ST_READ,
      ST_UPDATE,
      ST_N_START,
      ST_N_WAIT,
      ST_SEND
   } seq_state_type;

endpackage

// File: rtl/aph2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aph2d_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/aph2d_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module aph2d_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  aph2d_pkg::div_cmd_type cmd,
   output aph2d_pkg::div_stat_type stat
);
   import aph2d_pkg::*;

   logic [DIV_R_W-1:0]    rem_ff, rem_in;
   logic [DIV_Q_W-1:0]    num_ff, num_in;
   logic [DIV_R_W-1:0]    div_ff, div_in;
   logic [DIV_Q_W-1:0]    quo_ff, quo_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIV_R_W:0] trial;
   logic [DIV_R_W:0] diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, num_ff[DIV_Q_W-1]};
      diff = trial - {1'b0, div_ff};
      ge = (trial >= {1'b0, div_ff});

      rem_in = rem_ff;
      num_in = num_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         rem_in = cmd.rem_init;
         num_in = cmd.num_init;
         div_in = cmd.divisor;
         quo_in = '0;
         cnt_in = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         rem_in = ge ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
         num_in = {num_ff[DIV_Q_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_Q_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// File: rtl/angle_pair_histogram_2d.sv
// Top level of the angle pair histogram: sequencer, count store and divider.
//
// Usage:
//   req channel (valid/ready) carries one word per item: mode, two angles in
//   1/64 degree units for add mode, and a bin column/row for read mode.
//   rsp channel (valid/ready) returns one word per item: the bin, its count
//   after the item, count over peak as Q1.16, and the running peak.
//   The APB-style port writes bin_width_x at 0x0 and bin_width_y at 0x4;
//   write it only while no item is in flight. pready is tied high.
// Sequence (one item at a time):
//   add mode runs two 15-step angle divisions and one 17-step peak
//   division, all on the one shared restoring divider, plus a
//   read-modify-write of the count store. A zero bin width skips its
//   division. Read mode reads the count store and runs the peak division;
//   a zero peak skips that division too.
// Reset:
//   the count store is swept to zero, one entry per cycle, over all
//   BINS_PER_AXIS*BINS_PER_AXIS entries (4096 at 64 bins); req_ready stays
//   low meanwhile. Bin widths return to 640, the peak to zero.
// Stalls:
//   the result waits in an output register; the next item is accepted
//   while it waits, and its own result holds in the sequencer until the
//   output register frees up.
module angle_pair_histogram_2d #(
   parameter int BINS_PER_AXIS = aph2d_pkg::BINS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  aph2d_pkg::req_type req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output aph2d_pkg::rsp_type rsp_data,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import aph2d_pkg::*;

   localparam int BIN_W = (BINS_PER_AXIS > 1) ? $clog2(BINS_PER_AXIS) : 1;
   localparam int DEPTH = BINS_PER_AXIS * BINS_PER_AXIS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS_PER_AXIS - 1);
   localparam logic [DIV_Q_W-1:0] LAST_Q = DIV_Q_W'(BINS_PER_AXIS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   // Saturate a quotient or a query onto the last bin of the axis.
   function automatic logic [BIN_W-1:0] clamp_bin(input logic [DIV_Q_W-1:0] q);
      if (q > LAST_Q) begin
         clamp_bin = LAST_BIN;
      end else begin
         clamp_bin = BIN_W'(q);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [WIDTH_W-1:0] bwx_ff, bwx_in;
   logic [WIDTH_W-1:0] bwy_ff, bwy_in;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      bwx_in = bwx_ff;
      bwy_in = bwy_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_BIN_WIDTH_X: bwx_in = pwdata[WIDTH_W-1:0];
            REG_BIN_WIDTH_Y: bwy_in = pwdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_BIN_WIDTH_X: prdata = {{(32-WIDTH_W){1'b0}}, bwx_ff};
         REG_BIN_WIDTH_Y: prdata = {{(32-WIDTH_W){1'b0}}, bwy_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bwx_ff <= WIDTH_RESET;
         bwy_ff <= WIDTH_RESET;
      end else begin
         bwx_ff <= bwx_in;
         bwy_ff <= bwy_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state and item registers
   // ---------------------------------------------------------------------
   seq_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic                 mode_ff, mode_in;
   logic [ANGLE_W-1:0]   ax_ff, ax_in;
   logic [ANGLE_W-1:0]   ay_ff, ay_in;
   logic [BIN_W-1:0]     bx_ff, bx_in;
   logic [BIN_W-1:0]     by_ff, by_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   peak_ff, peak_in;
   logic [NORM_W-1:0]    norm_ff, norm_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // count store and divider hookup
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [COUNT_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [COUNT_W-1:0]   ram_rdata;
   logic [ADDR_W-1:0]    slot;
   logic [COUNT_W-1:0]   cnt_new;
   div_cmd_type          div_cmd;
   div_stat_type         div_stat;

   assign slot = ADDR_W'(bx_ff * BINS_PER_AXIS + by_ff);

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      mode_in = mode_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      cnt_in = cnt_ff;
      peak_in = peak_ff;
      norm_in = norm_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in = rsp_data_ff;

      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = slot;
      ram_wdata = '0;
      ram_raddr = slot;
      cnt_new = ram_rdata;

      div_cmd.start = 1'b0;
      div_cmd.rem_init = '0;
      div_cmd.num_init = '0;
      div_cmd.divisor = '0;
      div_cmd.steps = ANGLE_STEPS;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the store to zero, one entry per cycle
            ram_we = 1'b1;
            ram_waddr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = req_data.mode;
               ax_in = req_data.angle_x;
               ay_in = req_data.angle_y;
               bx_in = clamp_bin({{(DIV_Q_W-QUERY_W){1'b0}}, req_data.query_x});
               by_in = clamp_bin({{(DIV_Q_W-QUERY_W){1'b0}}, req_data.query_y});
               state_in = (req_data.mode == MODE_ADD) ? ST_X_START : ST_READ;
            end
         end

         ST_X_START: begin
            if (bwx_ff == '0) begin
               bx_in = LAST_BIN;
               state_in = ST_Y_START;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.num_init = {ax_ff, {(DIV_Q_W-ANGLE_W){1'b0}}};
               div_cmd.divisor = {{(DIV_R_W-WIDTH_W){1'b0}}, bwx_ff};
               div_cmd.steps = ANGLE_STEPS;
               state_in = ST_X_WAIT;
            end
         end

         ST_X_WAIT: begin
            if (div_stat.done) begin
               bx_in = clamp_bin(div_stat.quotient);
               state_in = ST_Y_START;
            end
         end

         ST_Y_START: begin
            if (bwy_ff == '0) begin
               by_in = LAST_BIN;
               state_in = ST_READ;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.num_init = {ay_ff, {(DIV_Q_W-ANGLE_W){1'b0}}};
               div_cmd.divisor = {{(DIV_R_W-WIDTH_W){1'b0}}, bwy_ff};
               div_cmd.steps = ANGLE_STEPS;
               state_in = ST_Y_WAIT;
            end
         end

         ST_Y_WAIT: begin
            if (div_stat.done) begin
               by_in = clamp_bin(div_stat.quotient);
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            // address goes out now, count comes back next cycle
            state_in = ST_UPDATE;
         end

         ST_UPDATE: begin
            if (mode_ff == MODE_ADD) begin
               cnt_new = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
               ram_we = 1'b1;
               ram_wdata = cnt_new;
               if (cnt_new > peak_ff) begin
                  peak_in = cnt_new;
               end
            end
            cnt_in = cnt_new;
            state_in = ST_N_START;
         end

         ST_N_START: begin
            if (peak_ff == '0) begin
               norm_in = '0;
               state_in = ST_SEND;
            end else begin
               // count never exceeds peak, so count>>1 fits below the divisor
               div_cmd.start = 1'b1;
               div_cmd.rem_init = {1'b0, cnt_ff[COUNT_W-1:1]};
               div_cmd.num_init = {cnt_ff[0], {(DIV_Q_W-1){1'b0}}};
               div_cmd.divisor = peak_ff;
               div_cmd.steps = NORM_STEPS;
               state_in = ST_N_WAIT;
            end
         end

         ST_N_WAIT: begin
            if (div_stat.done) begin
               norm_in = div_stat.quotient;
               state_in = ST_SEND;
            end
         end

         ST_SEND: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.bin_x = BIN_OUT_W'(bx_ff);
               rsp_data_in.bin_y = BIN_OUT_W'(by_ff);
               rsp_data_in.bin_count = cnt_ff;
               rsp_data_in.norm_value = norm_ff;
               rsp_data_in.peak = peak_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         peak_ff <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      cnt_ff <= cnt_in;
      norm_ff <= norm_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Count store and shared divider
   // ---------------------------------------------------------------------
   aph2d_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   aph2d_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

endmodule

// File: rtl/aph2d_checker.sv
// Port-level checks of the angle pair histogram, bound to the top level.
module aph2d_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input aph2d_pkg::rsp_type rsp_data
);
   import aph2d_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed or dropped under stall");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item in flight");

   // no bin can exceed the peak, and the fraction never exceeds one
   a_count_le_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bin_count <= rsp_data.peak) &&
                    (rsp_data.norm_value <= 17'h10000))
      else $error("bin count above peak or fraction above one");

   // empty histogram reads as zero
   a_zero_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.peak == '0) |-> (rsp_data.norm_value == '0))
      else $error("nonzero fraction with zero peak");

   // the peak bin normalizes to exactly one
   a_peak_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.peak != '0) && (rsp_data.bin_count == rsp_data.peak)
      |-> (rsp_data.norm_value == 17'h10000))
      else $error("peak bin does not normalize to one");

endmodule

bind angle_pair_histogram_2d aph2d_checker u_aph2d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
